@@ hdl/mac_interrupt_status_registers_unit_defines.svh @@
// Assertion macros shared by the interrupt status register slice.
`ifndef MAC_INTERRUPT_STATUS_REGISTERS_UNIT_DEFINES_SVH
`define MAC_INTERRUPT_STATUS_REGISTERS_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define MAC_ISR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MAC_ISR_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MAC_ISR_ASSERT(label, clk, rst, prop, msg)
`define MAC_ISR_ASSERT_NR(label, clk, prop, msg)
`endif

`endif

@@ hdl/mac_isr_pkg.sv @@
// Types and register map constants of the interrupt status register slice.
package mac_isr_pkg;

   localparam int OffsetWidth = 13;
   localparam int DataWidth   = 32;
   localparam int EventWidth  = 5;

   localparam logic [OffsetWidth-1:0] REG_INT_STATUS  = 13'h00b0;
   localparam logic [OffsetWidth-1:0] REG_INT_EN      = 13'h00b4;
   localparam logic [OffsetWidth-1:0] REG_PHYIF       = 13'h00f8;
   localparam logic [OffsetWidth-1:0] REG_VERSION     = 13'h0110;
   localparam logic [OffsetWidth-1:0] REG_BUS_MODE    = 13'h1000;
   localparam logic [OffsetWidth-1:0] REG_DMA_STATUS  = 13'h1008;
   localparam logic [OffsetWidth-1:0] REG_CHAN_BASE   = 13'h1100;
   localparam logic [OffsetWidth-1:0] CHAN_STATUS_OFS = 13'h0060;
   localparam logic [OffsetWidth-1:0] CHAN_INTEN_OFS  = 13'h0034;
   localparam logic [OffsetWidth-1:0] REG_CHAN_STATUS = REG_CHAN_BASE + CHAN_STATUS_OFS;
   localparam logic [OffsetWidth-1:0] REG_CHAN_INTEN  = REG_CHAN_BASE + CHAN_INTEN_OFS;

   localparam int ST_AIS_BIT     = 14;
   localparam int ST_NIS_BIT     = 15;
   localparam int PHY_LNKSTS_BIT = 19;

   localparam logic [1:0] SPEED_MAX = 2'd2;

   // CSR indexes
   localparam logic CSR_CORE_VERSION  = 1'b0;
   localparam logic CSR_LINK_ON_RESET = 1'b1;
   localparam logic [7:0] CORE_VERSION_RESET = 8'd82;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_DMA   = 2'd2,
      OP_LINK  = 2'd3
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [OffsetWidth-1:0] offset;
      logic [1:0]             access_size;
      logic [DataWidth-1:0]   write_data;
      logic [EventWidth-1:0]  event_bits;
      logic                   phy_link_up;
      logic [1:0]             phy_speed_code;
      logic                   phy_full_duplex;
   } req_word_type;

   typedef struct packed {
      logic [7:0] core_version;
      logic       link_on_reset;
   } cfg_type;

endpackage

@@ hdl/mac_isr_core.sv @@
// Register state, decode and update for one word of the interrupt status slice.
`include "mac_interrupt_status_registers_unit_defines.svh"

module mac_isr_core (
   input  logic                           clock,
   input  logic                           reset,
   input  mac_isr_pkg::cfg_type           cfg,
   input  mac_isr_pkg::req_word_type      word,
   input  logic                           fire,
   output logic [mac_isr_pkg::DataWidth-1:0] read_data,
   output logic                           irq
);
   import mac_isr_pkg::*;

   logic [DataWidth-1:0] chan_status_ff, chan_status_in;
   logic [DataWidth-1:0] chan_int_enable_ff, chan_int_enable_in;
   logic [DataWidth-1:0] mac_int_enable_ff, mac_int_enable_in;
   logic                 link_change_ff, link_change_in;
   logic                 irq_ff, irq_in;

   logic                   wide;
   logic [OffsetWidth-1:0] base;
   logic [4:0]             shift;
   logic [DataWidth-1:0]   shadow_val;
   logic [DataWidth-1:0]   read_val;
   logic [DataWidth-1:0]   read_mask;
   logic [DataWidth-1:0]   narrow_mask;
   logic [DataWidth-1:0]   write_val;
   logic [DataWidth-1:0]   link_val;
   logic [DataWidth-1:0]   event_val;
   logic [1:0]             speed;
   logic                   soft_reset;

   always_comb begin
      wide  = word.access_size[1];
      base  = wide ? word.offset : {word.offset[OffsetWidth-1:2], 2'b00};
      shift = wide ? 5'd0 : {word.offset[1:0], 3'b000};

      case (base)
         REG_INT_EN:      shadow_val = mac_int_enable_ff;
         REG_CHAN_INTEN:  shadow_val = chan_int_enable_ff;
         REG_CHAN_STATUS: shadow_val = chan_status_ff;
         default:         shadow_val = '0;
      endcase

      speed = (word.phy_speed_code > SPEED_MAX) ? SPEED_MAX : word.phy_speed_code;
      link_val = '0;
      if (word.phy_link_up) begin
         link_val[PHY_LNKSTS_BIT] = 1'b1;
         link_val[18:17]          = speed;
         link_val[16]             = word.phy_full_duplex;
      end

      case (base)
         REG_VERSION:    read_val = {{(DataWidth-8){1'b0}}, cfg.core_version};
         REG_INT_STATUS: read_val = {{(DataWidth-1){1'b0}}, link_change_ff};
         REG_PHYIF:      read_val = link_val;
         REG_DMA_STATUS: read_val = {{(DataWidth-1){1'b0}},
                                     |(chan_status_ff & chan_int_enable_ff)};
         default:        read_val = shadow_val;
      endcase

      read_mask   = wide ? '1 : (word.access_size[0] ? 32'h0000_ffff : 32'h0000_00ff);
      narrow_mask = (word.access_size[0] ? 32'h0000_ffff : 32'h0000_00ff) << shift;
      write_val   = wide ? word.write_data
                         : ((shadow_val & ~narrow_mask) |
                            ((word.write_data << shift) & narrow_mask));

      event_val              = '0;
      event_val[0]           = word.event_bits[0];
      event_val[2]           = word.event_bits[1];
      event_val[6]           = word.event_bits[2];
      event_val[7]           = word.event_bits[3];
      event_val[12]          = word.event_bits[4];
      event_val[ST_NIS_BIT]  = |word.event_bits[2:0];
      event_val[ST_AIS_BIT]  = |word.event_bits[4:3];

      soft_reset = (word.op == OP_WRITE) && (base == REG_BUS_MODE) && write_val[0];

      chan_status_in     = chan_status_ff;
      chan_int_enable_in = chan_int_enable_ff;
      mac_int_enable_in  = mac_int_enable_ff;
      link_change_in     = link_change_ff;
      read_data          = '0;

      case (word.op)
         OP_READ: begin
            read_data = (read_val >> shift) & read_mask;
            if (base == REG_PHYIF) begin
               link_change_in = 1'b0;
            end
         end
         OP_WRITE: begin
            case (base)
               REG_INT_EN:      mac_int_enable_in  = write_val;
               REG_CHAN_INTEN:  chan_int_enable_in = write_val;
               REG_CHAN_STATUS: chan_status_in     = chan_status_ff & ~write_val;
               REG_BUS_MODE: begin
                  if (write_val[0]) begin
                     chan_status_in     = '0;
                     chan_int_enable_in = '0;
                     mac_int_enable_in  = '0;
                     link_change_in     = cfg.link_on_reset & word.phy_link_up;
                  end
               end
               default: ;
            endcase
         end
         OP_DMA:  chan_status_in = chan_status_ff | event_val;
         OP_LINK: link_change_in = 1'b1;
         default: ;
      endcase

      irq_in = (|(chan_status_in & chan_int_enable_in)) |
               (link_change_in & mac_int_enable_in[0]);
      irq    = irq_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_status_ff     <= '0;
         chan_int_enable_ff <= '0;
         mac_int_enable_ff  <= '0;
         link_change_ff     <= 1'b0;
         irq_ff             <= 1'b0;
      end else if (fire) begin
         chan_status_ff     <= chan_status_in;
         chan_int_enable_ff <= chan_int_enable_in;
         mac_int_enable_ff  <= mac_int_enable_in;
         link_change_ff     <= link_change_in;
         irq_ff             <= irq_in;
      end
   end

   `MAC_ISR_ASSERT(a_irq_consistent, clock, reset, irq_ff == ((|(chan_status_ff & chan_int_enable_ff)) | (link_change_ff & mac_int_enable_ff[0])), "irq level out of step with status")
   `MAC_ISR_ASSERT(a_soft_reset_clears, clock, reset, (fire && soft_reset) |=> (chan_status_ff == '0 && !irq_ff && mac_int_enable_ff == '0), "soft reset left state behind")
   `MAC_ISR_ASSERT(a_link_event_latches, clock, reset, (fire && word.op == OP_LINK) |=> link_change_ff, "link change not latched")
   `MAC_ISR_ASSERT(a_idle_holds, clock, reset, !fire |=> ($stable(chan_status_ff) && $stable(link_change_ff)), "state moved without a word")

endmodule

@@ hdl/mac_interrupt_status_registers_unit.sv @@
// Top level of the Ethernet MAC interrupt and status register slice.
// Each request word (bus read, bus write, DMA condition or link change) passes
// through the input register and then the response register, and a new word is
// taken every cycle while the response side keeps up. Status state updates as
// the word leaves the input register; every request gets exactly one response.
module mac_interrupt_status_registers_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [1:0]                               req_op,
   input  logic [mac_isr_pkg::OffsetWidth-1:0]      req_offset,
   input  logic [1:0]                               req_access_size,
   input  logic [mac_isr_pkg::DataWidth-1:0]        req_write_data,
   input  logic [mac_isr_pkg::EventWidth-1:0]       req_event_bits,
   input  logic                                     req_phy_link_up,
   input  logic [1:0]                               req_phy_speed_code,
   input  logic                                     req_phy_full_duplex,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [mac_isr_pkg::DataWidth-1:0]        rsp_read_data,
   output logic                                     rsp_irq,
   input  logic                                     csr_write_enable,
   input  logic                                     csr_index,
   input  logic [7:0]                               csr_write_data
);
   import mac_isr_pkg::*;

   cfg_type              cfg_ff;
   req_word_type         word_ff;
   logic                 word_valid_ff;
   logic                 rsp_valid_ff;
   logic [DataWidth-1:0] rsp_read_data_ff;
   logic                 rsp_irq_ff;

   logic                 out_free;
   logic                 fire;
   logic [DataWidth-1:0] core_read_data;
   logic                 core_irq;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = word_valid_ff && out_free;
   assign req_ready = !word_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.core_version  <= CORE_VERSION_RESET;
         cfg_ff.link_on_reset <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CORE_VERSION:  cfg_ff.core_version  <= csr_write_data;
            CSR_LINK_ON_RESET: cfg_ff.link_on_reset <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= 1'b0;
      end else if (req_ready) begin
         word_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         word_ff.op              <= op_type'(req_op);
         word_ff.offset          <= req_offset;
         word_ff.access_size     <= req_access_size;
         word_ff.write_data      <= req_write_data;
         word_ff.event_bits      <= req_event_bits;
         word_ff.phy_link_up     <= req_phy_link_up;
         word_ff.phy_speed_code  <= req_phy_speed_code;
         word_ff.phy_full_duplex <= req_phy_full_duplex;
      end
   end

   mac_isr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .word      (word_ff),
      .fire      (fire),
      .read_data (core_read_data),
      .irq       (core_irq)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= word_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_read_data_ff <= core_read_data;
         rsp_irq_ff       <= core_irq;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_irq       = rsp_irq_ff;

endmodule
